// ----- design/rbsi_pkg.sv -----
`default_nettype none
package rbsi_pkg;

  // Default geometry: signed Q16.16 coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Axes of the box, one register each
  localparam int NUM_AXES = 3;

  // Register indexes on the configuration port
  localparam int REG_HALF_X = 0;
  localparam int REG_HALF_Y = 1;
  localparam int REG_HALF_Z = 2;

endpackage
`default_nettype wire

// ----- design/rbsi_cfg.sv -----
`default_nettype none
module rbsi_cfg #(
  parameter int REG_W     = 31,
  parameter int DATA_W    = 32,
  parameter int ADDR_W    = 4,
  parameter int RESET_VAL = 32768
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [REG_W-1:0]  half_o [rbsi_pkg::NUM_AXES]
);

  localparam int ADDR_LSB = ADDR_W - 2;

  logic [REG_W-1:0] half_q [rbsi_pkg::NUM_AXES];
  logic [1:0]       idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:ADDR_LSB];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write one half extent; drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < rbsi_pkg::NUM_AXES; a++) begin
        half_q[a] <= REG_W'(RESET_VAL);
      end
    end else if (wr && (int'(idx) < rbsi_pkg::NUM_AXES)) begin
      half_q[idx] <= pwdata[REG_W-1:0];
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    if (int'(idx) == rbsi_pkg::REG_HALF_X) begin
      prdata = DATA_W'(half_q[rbsi_pkg::REG_HALF_X]);
    end else if (int'(idx) == rbsi_pkg::REG_HALF_Y) begin
      prdata = DATA_W'(half_q[rbsi_pkg::REG_HALF_Y]);
    end else if (int'(idx) == rbsi_pkg::REG_HALF_Z) begin
      prdata = DATA_W'(half_q[rbsi_pkg::REG_HALF_Z]);
    end
  end

  assign half_o = half_q;

endmodule
`default_nettype wire

// ----- design/rbsi_slab.sv -----
`default_nettype none
module rbsi_slab #(
  parameter int CW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [CW-1:0] start_i,
  input  wire logic signed [CW-1:0] end_i,
  input  wire logic        [CW-2:0] half_i,
  output logic                      miss_o,
  output logic             [CW-1:0] ent_num_o,
  output logic             [CW-1:0] ent_den_o,
  output logic             [CW-1:0] ext_num_o,
  output logic             [CW-1:0] ext_den_o,
  output logic             [CW-1:0] start_o,
  output logic             [CW-1:0] absd_o,
  output logic                      neg_o
);

  localparam int XW = CW + 2;

  logic signed [XW-1:0] s, e, h, nh, dm;
  logic signed [XW-1:0] en_num, en_den, ex_num, ex_den;
  logic                 lt, miss;

  logic          miss_q, neg_q;
  logic [CW-1:0] en_num_q, en_den_q, ex_num_q, ex_den_q, s_q, absd_q;

  // Classify the slab and set up entry and exit quotients
  always_comb begin
    s  = XW'(start_i);
    e  = XW'(end_i);
    h  = $signed({2'b00, half_i, 1'b0}) >>> 1;
    nh = -h;
    lt = s < e;
    dm = lt ? (e - s) : (s - e);
    en_num = '0;
    en_den = XW'(1);
    ex_num = XW'(1);
    ex_den = XW'(1);
    if (lt) begin
      miss = (s > h) || (e < nh);
      if (s < nh) begin
        en_num = nh - s;
        en_den = dm;
      end
      if (e > h) begin
        ex_num = h - s;
        ex_den = dm;
      end
    end else begin
      miss = (e > h) || (s < nh);
      if (s > h) begin
        en_num = s - h;
        en_den = dm;
      end
      if (e < nh) begin
        ex_num = s + h;
        ex_den = dm;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      miss_q   <= miss;
      en_num_q <= en_num[CW-1:0];
      en_den_q <= en_den[CW-1:0];
      ex_num_q <= ex_num[CW-1:0];
      ex_den_q <= ex_den[CW-1:0];
      s_q      <= start_i;
      absd_q   <= dm[CW-1:0];
      neg_q    <= s > e;
    end
  end

  assign miss_o    = miss_q;
  assign ent_num_o = en_num_q;
  assign ent_den_o = en_den_q;
  assign ext_num_o = ex_num_q;
  assign ext_den_o = ex_den_q;
  assign start_o   = s_q;
  assign absd_o    = absd_q;
  assign neg_o     = neg_q;

endmodule
`default_nettype wire

// ----- design/rbsi_div.sv -----
`default_nettype none
module rbsi_div #(
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int ND = 9
) (
  input  wire logic          clk_i,
  input  wire logic [ND-1:0] en_i,
  input  wire logic [DW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o
);

  logic [DW:0]   rem_q [ND];
  logic [DW-1:0] den_q [ND];
  logic [QW-1:0] quo_q [ND];

  // Two restoring steps; the first step of all takes no shift
  function automatic logic [DW+QW:0] div_stage(logic [DW:0] r_in, logic [DW-1:0] d,
                                               logic [QW-1:0] q_in, int base);
    logic [DW:0]   r;
    logic [QW-1:0] q;
    r = r_in;
    q = q_in;
    for (int k = 0; k < 2; k++) begin
      if (base + k < QW) begin
        if (base + k != 0) begin
          r = {r[DW-1:0], 1'b0};
        end
        if (r >= {1'b0, d}) begin
          r = r - {1'b0, d};
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
      end
    end
    return {r, q};
  endfunction

  for (genvar j = 0; j < ND; j++) begin : g_stage
    logic [DW:0]    r_in;
    logic [DW-1:0]  d_in;
    logic [QW-1:0]  q_in;
    logic [DW+QW:0] res;

    if (j == 0) begin : g_first
      assign r_in = {1'b0, num_i};
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[j-1];
      assign d_in = den_q[j-1];
      assign q_in = quo_q[j-1];
    end

    assign res = div_stage(r_in, d_in, q_in, 2 * j);

    // Advance the partial remainder and quotient
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= res[DW+QW:QW];
        den_q[j] <= d_in;
        quo_q[j] <= res[QW-1:0];
      end
    end
  end

  assign quo_o = quo_q[ND-1];

endmodule
`default_nettype wire

// ----- design/rbsi_lerp.sv -----
`default_nettype none
module rbsi_lerp #(
  parameter int CW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic [2:0]              en_i,
  input  wire logic                    miss_i,
  input  wire logic [FRAC_BITS:0]      ent_i   [rbsi_pkg::NUM_AXES],
  input  wire logic [FRAC_BITS:0]      ext_i   [rbsi_pkg::NUM_AXES],
  input  wire logic [CW-1:0]           start_i [rbsi_pkg::NUM_AXES],
  input  wire logic [CW-1:0]           absd_i  [rbsi_pkg::NUM_AXES],
  input  wire logic [rbsi_pkg::NUM_AXES-1:0] neg_i,
  output logic                         hit_o,
  output logic      [FRAC_BITS:0]      frac_o,
  output logic      [CW-1:0]           point_o [rbsi_pkg::NUM_AXES]
);

  localparam int QW = FRAC_BITS + 1;
  localparam int PW = CW + QW;
  localparam int NA = rbsi_pkg::NUM_AXES;

  logic [QW-1:0] fst, fet;

  logic          hit0_q, hit1_q, hit2_q;
  logic [QW-1:0] t0_q, t1_q, t2_q;
  logic [CW-1:0] s0_q [NA];
  logic [CW-1:0] s1_q [NA];
  logic [CW-1:0] d0_q [NA];
  logic [PW-1:0] p1_q [NA];
  logic [CW-1:0] pt2_q [NA];
  logic [NA-1:0] n0_q, n1_q;

  // Keep the latest entry and the earliest exit
  always_comb begin
    fst = ent_i[0];
    fet = ext_i[0];
    for (int a = 1; a < NA; a++) begin
      if (ent_i[a] > fst) fst = ent_i[a];
      if (ext_i[a] < fet) fet = ext_i[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hit0_q <= !miss_i && !(fet < fst);
      t0_q   <= fst;
      s0_q   <= start_i;
      d0_q   <= absd_i;
      n0_q   <= neg_i;
    end
  end

  // Scale each axis span by t
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hit1_q <= hit0_q;
      t1_q   <= t0_q;
      s1_q   <= s0_q;
      n1_q   <= n0_q;
      for (int a = 0; a < NA; a++) begin
        p1_q[a] <= PW'(d0_q[a]) * PW'(t0_q);
      end
    end
  end

  // Step from the start point; zero everything on a miss
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hit2_q <= hit1_q;
      t2_q   <= hit1_q ? t1_q : '0;
      for (int a = 0; a < NA; a++) begin
        if (!hit1_q) begin
          pt2_q[a] <= '0;
        end else if (n1_q[a]) begin
          pt2_q[a] <= s1_q[a] - p1_q[a][FRAC_BITS +: CW];
        end else begin
          pt2_q[a] <= s1_q[a] + p1_q[a][FRAC_BITS +: CW];
        end
      end
    end
  end

  assign hit_o   = hit2_q;
  assign frac_o  = t2_q;
  assign point_o = pt2_q;

endmodule
`default_nettype wire

// ----- design/ray_box_slab_intersect.sv -----
`default_nettype none
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    start_x/y/z_i, end_x/y/z_i
// out       out_valid_o / out_ready_i  hit_o, entry_fraction_o, hit_x/y/z_o
// cfg       psel/penable/pwrite/pready paddr, pwdata, prdata (half extents)
//
// One item per cycle while out_ready_i is high; 4 + (FRAC_BITS+2)/2 register
// stages, and out_valid_o is the valid bit of the last one. The restoring divider
// resolves two quotient bits per stage. Each stage holds its own valid bit and
// stalls only when the stage after it is full and stalled, so bubbles close up
// under back-pressure and no item is lost. Reset clears the valid bits and loads
// every half extent with 0.5.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
  localparam int REG_W      = COORD_WIDTH - 1,
  localparam int DATA_W     = (REG_W > 32) ? 64 : 32,
  localparam int ADDR_W     = ((DATA_W == 64) ? 3 : 2) + 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [DATA_W-1:0]             pwdata,
  output logic      [DATA_W-1:0]             prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               hit_o,
  output logic      [FRAC_BITS:0]            entry_fraction_o,
  output logic signed [COORD_WIDTH-1:0]      hit_x_o,
  output logic signed [COORD_WIDTH-1:0]      hit_y_o,
  output logic signed [COORD_WIDTH-1:0]      hit_z_o
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = FRAC_BITS + 1;
  localparam int ND = (QW + 1) / 2;
  localparam int NS = 1 + ND + 3;
  localparam int NA = rbsi_pkg::NUM_AXES;

  logic [REG_W-1:0] half [NA];
  logic [CW-1:0]    st_in [NA];
  logic [CW-1:0]    en_in [NA];

  logic [NS-1:0] v_q, en;

  logic [NA-1:0] ax_miss, ax_neg;
  logic [CW-1:0] ent_num [NA];
  logic [CW-1:0] ent_den [NA];
  logic [CW-1:0] ext_num [NA];
  logic [CW-1:0] ext_den [NA];
  logic [CW-1:0] ax_s    [NA];
  logic [CW-1:0] ax_d    [NA];
  logic [QW-1:0] ent_q   [NA];
  logic [QW-1:0] ext_q   [NA];

  logic          sd_miss_q [ND];
  logic [NA-1:0] sd_neg_q  [ND];
  logic [CW-1:0] sd_s_q    [ND][NA];
  logic [CW-1:0] sd_d_q    [ND][NA];

  logic [CW-1:0] point [NA];

  rbsi_cfg #(
    .REG_W    (REG_W),
    .DATA_W   (DATA_W),
    .ADDR_W   (ADDR_W),
    .RESET_VAL(1 << (FRAC_BITS - 1))
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .half_o (half)
  );

  // Stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  assign st_in[0] = start_x_i;
  assign st_in[1] = start_y_i;
  assign st_in[2] = start_z_i;
  assign en_in[0] = end_x_i;
  assign en_in[1] = end_y_i;
  assign en_in[2] = end_z_i;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    rbsi_slab #(
      .CW(CW)
    ) u_slab (
      .clk_i    (clk_i),
      .en_i     (en[0]),
      .start_i  ($signed(st_in[a])),
      .end_i    ($signed(en_in[a])),
      .half_i   (half[a]),
      .miss_o   (ax_miss[a]),
      .ent_num_o(ent_num[a]),
      .ent_den_o(ent_den[a]),
      .ext_num_o(ext_num[a]),
      .ext_den_o(ext_den[a]),
      .start_o  (ax_s[a]),
      .absd_o   (ax_d[a]),
      .neg_o    (ax_neg[a])
    );

    rbsi_div #(
      .DW(CW),
      .QW(QW),
      .ND(ND)
    ) u_div_ent (
      .clk_i(clk_i),
      .en_i (en[ND:1]),
      .num_i(ent_num[a]),
      .den_i(ent_den[a]),
      .quo_o(ent_q[a])
    );

    rbsi_div #(
      .DW(CW),
      .QW(QW),
      .ND(ND)
    ) u_div_ext (
      .clk_i(clk_i),
      .en_i (en[ND:1]),
      .num_i(ext_num[a]),
      .den_i(ext_den[a]),
      .quo_o(ext_q[a])
    );
  end

  // Carry the miss flag and span data alongside the dividers
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ND; j++) begin
      if (en[1+j]) begin
        if (j == 0) begin
          sd_miss_q[j] <= |ax_miss;
          sd_neg_q[j]  <= ax_neg;
          sd_s_q[j]    <= ax_s;
          sd_d_q[j]    <= ax_d;
        end else begin
          sd_miss_q[j] <= sd_miss_q[(j == 0) ? 0 : j - 1];
          sd_neg_q[j]  <= sd_neg_q[(j == 0) ? 0 : j - 1];
          sd_s_q[j]    <= sd_s_q[(j == 0) ? 0 : j - 1];
          sd_d_q[j]    <= sd_d_q[(j == 0) ? 0 : j - 1];
        end
      end
    end
  end

  rbsi_lerp #(
    .CW       (CW),
    .FRAC_BITS(FRAC_BITS)
  ) u_lerp (
    .clk_i  (clk_i),
    .en_i   (en[NS-1:ND+1]),
    .miss_i (sd_miss_q[ND-1]),
    .ent_i  (ent_q),
    .ext_i  (ext_q),
    .start_i(sd_s_q[ND-1]),
    .absd_i (sd_d_q[ND-1]),
    .neg_i  (sd_neg_q[ND-1]),
    .hit_o  (hit_o),
    .frac_o (entry_fraction_o),
    .point_o(point)
  );

  assign hit_x_o = $signed(point[0]);
  assign hit_y_o = $signed(point[1]);
  assign hit_z_o = $signed(point[2]);

endmodule
`default_nettype wire

// ----- bench/tb_ray_box_slab_intersect.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_ray_box_slab_intersect;

  localparam int CW = rbsi_pkg::COORD_WIDTH_DEF;
  localparam int FB = rbsi_pkg::FRAC_BITS_DEF;
  localparam int AW = 4;
  localparam int LATENCY = 4 + (FB + 2) / 2;
  localparam longint ONE_Q = 64'd1 << FB;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    logic            hit;
    logic [FB:0]     frac;
    logic signed [CW-1:0] px, py, pz;
  } hit_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [CW-1:0] start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i;
  logic hit_o;
  logic [FB:0] entry_fraction_o;
  logic signed [CW-1:0] hit_x_o, hit_y_o, hit_z_o;

  ray_box_slab_intersect dut (.*);

  segment_t segment_q[$];
  hit_t     hit_expect_q[$];
  longint   half_ext[3];
  int       mismatch_cnt;
  int       send_idle_pct, recv_idle_pct;
  bit       hold_rx;
  bit       cfg_busy;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Truncated fraction num/den in Q1.FB, saturated at one
  function automatic longint frac_div(longint num, longint den);
    longint q;
    if (den == 0) return ONE_Q;
    q = (num << FB) / den;
    return (q > ONE_Q) ? ONE_Q : q;
  endfunction

  function automatic logic [CW-1:0] lerp(longint s, longint e, longint t);
    if (e >= s) return CW'(s + (((e - s) * t) >>> FB));
    return CW'(s - (((s - e) * t) >>> FB));
  endfunction

  // Slab test over three axes
  function automatic hit_t predict_hit(segment_t g);
    hit_t r;
    longint s[3], e[3], h, st, et, t_in, t_out;
    bit miss;
    s[0] = g.sx; s[1] = g.sy; s[2] = g.sz;
    e[0] = g.ex; e[1] = g.ey; e[2] = g.ez;
    t_in = 0; t_out = ONE_Q; miss = 0;
    for (int i = 0; i < 3; i++) begin
      if (!miss) begin
        h = half_ext[i];
        if (s[i] < e[i]) begin
          if (s[i] > h || e[i] < -h) miss = 1;
          else begin
            st = (s[i] < -h) ? frac_div(-h - s[i], e[i] - s[i]) : 0;
            et = (e[i] > h) ? frac_div(h - s[i], e[i] - s[i]) : ONE_Q;
          end
        end else begin
          if (e[i] > h || s[i] < -h) miss = 1;
          else begin
            st = (s[i] > h) ? frac_div(s[i] - h, s[i] - e[i]) : 0;
            et = (e[i] < -h) ? frac_div(s[i] + h, s[i] - e[i]) : ONE_Q;
          end
        end
        if (!miss) begin
          if (st > t_in) t_in = st;
          if (et < t_out) t_out = et;
          if (t_out < t_in) miss = 1;
        end
      end
    end
    r = '0;
    if (!miss) begin
      r.hit = 1'b1;
      r.frac = t_in[FB:0];
      r.px = lerp(s[0], e[0], t_in);
      r.py = lerp(s[1], e[1], t_in);
      r.pz = lerp(s[2], e[2], t_in);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // Drive items from the pending queue and record the prediction for each accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        hit_expect_q.push_back(predict_hit({start_x_i, start_y_i, start_z_i,
                                            end_x_i, end_y_i, end_z_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (segment_q.size() > 0 && !cfg_busy &&
            $urandom_range(99) >= send_idle_pct) begin
          {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} <=
            segment_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check results and randomize the ready
  always @(posedge clk_i) begin
    hit_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (hit_expect_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          w = hit_expect_q.pop_front();
          if (hit_o !== w.hit) report_mismatch("hit", hit_o, w.hit);
          if (entry_fraction_o !== w.frac)
            report_mismatch("entry_fraction", entry_fraction_o, w.frac);
          if (hit_x_o !== w.px) report_mismatch("hit_x", hit_x_o, w.px);
          if (hit_y_o !== w.py) report_mismatch("hit_y", hit_y_o, w.py);
          if (hit_z_o !== w.pz) report_mismatch("hit_z", hit_z_o, w.pz);
        end
      end
      if (hold_rx) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_half(int idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < 3) half_ext[idx] = val & 32'h7fff_ffff;
  endtask

  // Hold the sender once the queue is empty, then wait for the block to empty
  task automatic wait_drained();
    while (segment_q.size() > 0 || in_valid_i || hit_expect_q.size() > 0)
      @(posedge clk_i);
    cfg_busy = 1;
    @(posedge clk_i);
    while (in_valid_i || hit_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord(longint h);
    case ($urandom_range(4))
      0: return CW'($urandom);
      1: return CW'(longint'($urandom_range(2 * 65536 * 4)) - 4 * 65536);
      2: return CW'(h);
      3: return CW'(-h);
      default: return CW'(longint'($urandom_range(4 * h + 8)) - 2 * h - 4);
    endcase
  endfunction

  task automatic add_random(int n);
    segment_t g;
    longint hm;
    repeat (n) begin
      hm = half_ext[0];
      if (half_ext[1] > hm) hm = half_ext[1];
      if (half_ext[2] > hm) hm = half_ext[2];
      if (hm > 64'h1000_0000) hm = 64'h1000_0000;
      g = {rand_coord(hm), rand_coord(hm), rand_coord(hm),
           rand_coord(hm), rand_coord(hm), rand_coord(hm)};
      if ($urandom_range(9) == 0) g.ex = g.sx;
      segment_q.push_back(g);
    end
  endtask

  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  initial begin
    logic [31:0] wv;
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; out_ready_i = 0; hold_rx = 0; cfg_busy = 1;
    {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} = '0;
    mismatch_cnt = 0; send_idle_pct = 15; recv_idle_pct = 83;
    half_ext[0] = 32768; half_ext[1] = 32768; half_ext[2] = 32768;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset box, extremes, degenerate axes, face touches
    segment_q.push_back({MINC, MINC, MINC, MAXC, MAXC, MAXC});
    segment_q.push_back({MAXC, MAXC, MAXC, MINC, MINC, MINC});
    segment_q.push_back({-32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
    segment_q.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    segment_q.push_back({32'sd40000, 32'sd0, 32'sd0, 32'sd40000, 32'sd0, 32'sd0});
    segment_q.push_back({32'sd32768, 32'sd0, 32'sd0, 32'sd32768, 32'sd0, 32'sd0});
    segment_q.push_back({-32'sd65536, 32'sd32768, 32'sd0, 32'sd0, 32'sd32768, 32'sd0});
    segment_q.push_back({32'sd65536, 32'sd65536, 32'sd0, -32'sd65536, -32'sd65536, 32'sd0});
    segment_q.push_back({32'sd98304, -32'sd65536, 32'sd0, 32'sd0, 32'sd98304, 32'sd0});
    segment_q.push_back({-32'sd65536, -32'sd65536, -32'sd65536,
                         32'sd65536, 32'sd65536, 32'sd65536});
    segment_q.push_back({32'sd100000, 32'sd0, 32'sd0, 32'sd200000, 32'sd0, 32'sd0});
    segment_q.push_back({-32'sd1, 32'sd0, 32'sd0, MAXC, 32'sd0, 32'sd0});
    cfg_busy = 0;
    wait_drained();

    // Zero extents: point box
    for (int i = 0; i < 4; i++) write_half(i, 32'h0);
    segment_q.push_back({-32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
    segment_q.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    segment_q.push_back({-32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 32'sd65536, 32'sd0});
    add_random(60);
    cfg_busy = 0;
    wait_drained();

    // Largest extents, upper bit ignored
    write_half(0, 32'hffff_ffff); write_half(1, 32'h7fff_ffff); write_half(2, 32'h8000_0000);
    segment_q.push_back({MINC, MINC, MINC, MAXC, MAXC, MAXC});
    segment_q.push_back({MAXC, 32'sd0, 32'sd0, MINC, 32'sd0, 32'sd0});
    add_random(80);
    cfg_busy = 0;
    wait_drained();

    // Random boxes across three idle profiles
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 83; recv_idle_pct = 15; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(3))
          0: wv = $urandom;
          1: wv = $urandom_range(4 * 65536);
          2: wv = $urandom_range(65536);
          default: wv = $urandom_range(16);
        endcase
        write_half(i, wv);
      end
      add_random(140);
      cfg_busy = 0;
      if (ph == 7) begin
        repeat (20) @(posedge clk_i);
        // Hold off the receiver for a long stretch in its own process
        fork
          begin
            hold_rx = 1;
            repeat (200) @(posedge clk_i);
            hold_rx = 0;
          end
        join_none
      end
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ----- ray_box_slab_intersect.f -----
design/rbsi_pkg.sv
design/rbsi_cfg.sv
design/rbsi_slab.sv
design/rbsi_div.sv
design/rbsi_lerp.sv
design/ray_box_slab_intersect.sv
bench/tb_ray_box_slab_intersect.sv
